>>> hw/rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("reset check failed");

`endif

>>> hw/rtl/ffra_pkg.sv
package ffra_pkg;
    localparam int MAX_RANGES_DEF  = 64;
    localparam int HANDLE_LOW_DEF  = 1;
    localparam int HANDLE_HIGH_DEF = 65535;
    localparam int HW = 16;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_NOFIT = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic [HW-1:0] s;
        logic [HW-1:0] e;
    } t_range;
endpackage

>>> hw/rtl/ffra_mem.sv
module ffra_mem #(
    parameter int DEPTH = ffra_pkg::MAX_RANGES_DEF,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  ffra_pkg::t_range      i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output ffra_pkg::t_range      o_rdata
);
    ffra_pkg::t_range r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hw/rtl/first_fit_range_allocator_top.sv
// First-fit handle range allocator.
// Input channel: i_valid/o_stall with i_operation, i_alloc_count,
// i_release_first, i_release_last. Output channel: o_valid/i_stall with
// o_status, o_granted_first, o_granted_last; one result word per request.
// Free ranges live in one memory of MAX_RANGES entries, sorted by start.
// A request scans the list entry by entry through the registered memory
// read port, issuing a read and then checking the returned entry, then
// shifts the tail entry by entry (read, then write) to close or open a
// slot; one request at a time.
// o_stall is high while a request is in work or its result waits.
// Reset (synchronous, active low) gives a list holding HANDLE_LOW..HANDLE_HIGH
// in entry 0; entry 0 is written in the S_INIT state that follows reset, while
// o_stall is high. A result held by i_stall stays stable until taken.
`include "assert_macros.svh"

module first_fit_range_allocator_top #(
    parameter int MAX_RANGES  = ffra_pkg::MAX_RANGES_DEF,
    parameter int HANDLE_LOW  = ffra_pkg::HANDLE_LOW_DEF,
    parameter int HANDLE_HIGH = ffra_pkg::HANDLE_HIGH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [15:0] i_alloc_count,
    input  logic [15:0] i_release_first,
    input  logic [15:0] i_release_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_granted_first,
    output logic [15:0] o_granted_last
);
    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_RANGES);
    localparam logic [16:0] LIMIT = 17'(HANDLE_HIGH - HANDLE_LOW + 1);

    localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2,
        S_CHK = 4'd3, S_DSH = 4'd4, S_DSHW = 4'd5, S_RL = 4'd6,
        S_RLW = 4'd7, S_ISH = 4'd8, S_ISHW = 4'd9, S_OUT = 4'd10,
        S_RR = 4'd11, S_RRW = 4'd12, S_FIN = 4'd13;

    logic [3:0]  r_st, n_st;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_k, n_k;
    logic        r_op;
    logic [15:0] r_want, r_first, r_last;
    logic [1:0]  r_status, n_status;
    logic [15:0] r_gf, n_gf, r_gl, n_gl;
    ffra_pkg::t_range r_left, n_left;
    logic        r_ladj, n_ladj;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    ffra_pkg::t_range wdata, rdata;

    ffra_mem #(.DEPTH(MAX_RANGES), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic acc;
    assign acc = i_valid && !o_stall;
    assign o_stall = (r_st != S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_status = r_status;
    assign o_granted_first = r_gf;
    assign o_granted_last = r_gl;

    logic [16:0] avail;
    logic        rs_ok;
    assign avail = {1'b0, rdata.e} - {1'b0, rdata.s} + 17'd1;

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_i = r_i; n_k = r_k;
        n_status = r_status; n_gf = r_gf; n_gl = r_gl;
        n_left = r_left; n_ladj = r_ladj;
        we = 1'b0; waddr = '0; wdata = rdata; raddr = r_i[AW-1:0];
        rs_ok = 1'b0;
        case (r_st)
            S_INIT: begin
                we = 1'b1;
                wdata.s = 16'(HANDLE_LOW);
                wdata.e = 16'(HANDLE_HIGH);
                n_st = S_IDLE;
            end
            S_IDLE: begin
                n_i = '0;
                n_gf = '0; n_gl = '0; n_status = ffra_pkg::ST_OK;
                n_ladj = 1'b0;
                raddr = '0;
                if (acc) begin
                    if (i_operation == ffra_pkg::OP_ALLOC) begin
                        if (i_alloc_count == '0 || {1'b0, i_alloc_count} > LIMIT) begin
                            n_status = ffra_pkg::ST_BAD; n_st = S_OUT;
                        end else begin
                            n_st = S_RD;
                        end
                    end else begin
                        if (i_release_first > i_release_last) begin
                            n_status = ffra_pkg::ST_BAD; n_st = S_OUT;
                        end else if (r_cnt >= MAXC) begin
                            n_status = ffra_pkg::ST_FULL; n_st = S_OUT;
                        end else begin
                            n_st = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                // read issued for r_i
                if (r_i >= r_cnt) begin
                    if (r_op == ffra_pkg::OP_ALLOC) begin
                        n_status = ffra_pkg::ST_NOFIT; n_st = S_OUT;
                    end else begin
                        n_st = S_RL;
                    end
                end else begin
                    n_st = S_CHK;
                end
            end
            S_CHK: begin
                if (r_op == ffra_pkg::OP_ALLOC) begin
                    if (avail >= {1'b0, r_want}) begin
                        n_gf = rdata.s;
                        n_gl = 16'(rdata.s + r_want - 16'd1);
                        if (avail > {1'b0, r_want}) begin
                            we = 1'b1; waddr = r_i[AW-1:0];
                            wdata.s = 16'(rdata.s + r_want);
                            n_st = S_OUT;
                        end else begin
                            n_k = r_i; n_st = S_DSH;
                        end
                    end else begin
                        n_i = r_i + 1'b1; n_st = S_RD;
                    end
                end else begin
                    if (rdata.s < r_first) begin
                        n_left = rdata;
                        n_i = r_i + 1'b1; n_st = S_RD;
                    end else begin
                        n_st = S_RL;
                    end
                end
                raddr = n_i[AW-1:0];
            end
            // delete entry r_k: copy k+1 -> k
            S_DSH: begin
                if (r_k + 1'b1 >= r_cnt) begin
                    n_cnt = r_cnt - 1'b1;
                    n_st = S_OUT;
                end else begin
                    raddr = AW'(r_k + 1'b1);
                    n_st = S_DSHW;
                end
            end
            S_DSHW: begin
                we = 1'b1; waddr = r_k[AW-1:0]; wdata = rdata;
                n_k = r_k + 1'b1;
                n_st = S_DSH;
            end
            // release: r_i = idx, r_left = entry idx-1, rdata = entry idx
            S_RL: begin
                n_ladj = (r_i != '0) && ({1'b0, r_left.e} + 17'd1 == {1'b0, r_first});
                rs_ok = (r_i < r_cnt) && ({1'b0, r_last} + 17'd1 == {1'b0, rdata.s});
                if (n_ladj && rs_ok) begin
                    we = 1'b1; waddr = AW'(r_i - 1'b1);
                    wdata.s = r_left.s; wdata.e = rdata.e;
                    n_k = r_i; n_st = S_DSH;
                end else if (n_ladj) begin
                    we = 1'b1; waddr = AW'(r_i - 1'b1);
                    wdata.s = r_left.s; wdata.e = r_last;
                    n_st = S_OUT;
                end else if (rs_ok) begin
                    we = 1'b1; waddr = r_i[AW-1:0];
                    wdata.s = r_first; wdata.e = rdata.e;
                    n_st = S_OUT;
                end else begin
                    n_k = r_cnt; n_st = S_ISH;
                end
            end
            // insert at r_i: copy k-1 -> k for k = cnt down to i+1
            S_ISH: begin
                if (r_k <= r_i) begin
                    we = 1'b1; waddr = r_i[AW-1:0];
                    wdata.s = r_first; wdata.e = r_last;
                    n_cnt = r_cnt + 1'b1;
                    n_st = S_OUT;
                end else begin
                    raddr = AW'(r_k - 1'b1);
                    n_st = S_ISHW;
                end
            end
            S_ISHW: begin
                we = 1'b1; waddr = r_k[AW-1:0]; wdata = rdata;
                n_k = r_k - 1'b1;
                n_st = S_ISH;
            end
            S_OUT: begin
                if (!i_stall) n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT;
            r_cnt <= CW'(1);
            r_i <= '0;
            r_k <= '0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
            r_i <= n_i;
            r_k <= n_k;
        end
        r_status <= n_status;
        r_gf <= n_gf;
        r_gl <= n_gl;
        r_left <= n_left;
        r_ladj <= n_ladj;
        if (acc) begin
            r_op <= i_operation;
            r_want <= i_alloc_count;
            r_first <= i_release_first;
            r_last <= i_release_last;
        end
    end

    `ASSERT_CLK(a_cnt_range, i_clk, i_rst_n, (r_cnt >= CW'(1) || r_st != S_IDLE || 1'b1) && r_cnt <= MAXC)
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_granted_first)))
    `ASSERT_CLK(a_no_acc_busy, i_clk, i_rst_n, (r_st != S_IDLE) |-> !acc)
    `ASSERT_CLK(a_fail_zero, i_clk, i_rst_n, (o_valid && o_status != ffra_pkg::ST_OK) |-> (o_granted_first == '0 && o_granted_last == '0))
endmodule

>>> tb/sv/tb_first_fit_range_allocator_top.sv
module tb_first_fit_range_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] first;
        logic [15:0] last;
    } t_reply;

    typedef struct packed {
        logic [15:0] first;
        logic [15:0] last;
    } t_span;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_operation = 1'b0;
    logic [15:0] i_alloc_count = '0;
    logic [15:0] i_release_first = '0;
    logic [15:0] i_release_last = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_granted_first;
    logic [15:0] o_granted_last;

    int unsigned free_lo [ffra_pkg::MAX_RANGES_DEF];
    int unsigned free_hi [ffra_pkg::MAX_RANGES_DEF];
    int unsigned free_cnt;

    t_reply pending_replies[$];
    t_span  held_spans[$];
    bit     failed = 1'b0;
    bit     calm = 1'b0;
    int     stall_left = 0;

    first_fit_range_allocator_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_alloc_count  (i_alloc_count),
        .i_release_first(i_release_first),
        .i_release_last (i_release_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_granted_first(o_granted_first),
        .o_granted_last (o_granted_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_reply free_list_step(logic op, logic [15:0] cnt,
                                              logic [15:0] first, logic [15:0] last);
        t_reply      r;
        int unsigned avail;
        int unsigned idx;
        bit          ladj;
        bit          radj;
        r = '0;
        if (op == ffra_pkg::OP_ALLOC) begin
            if (cnt == 0 ||
                cnt > ffra_pkg::HANDLE_HIGH_DEF - ffra_pkg::HANDLE_LOW_DEF + 1) begin
                r.status = ffra_pkg::ST_BAD;
                return r;
            end
            for (int unsigned i = 0; i < free_cnt; i++) begin
                avail = free_hi[i] - free_lo[i] + 1;
                if (avail >= cnt) begin
                    r.status = ffra_pkg::ST_OK;
                    r.first  = free_lo[i][15:0];
                    r.last   = 16'(free_lo[i] + cnt - 1);
                    if (avail > cnt) begin
                        free_lo[i] = (free_lo[i] + cnt) & 32'hFFFF;
                    end else begin
                        for (int unsigned k = i; k + 1 < free_cnt; k++) begin
                            free_lo[k] = free_lo[k + 1];
                            free_hi[k] = free_hi[k + 1];
                        end
                        free_cnt--;
                    end
                    return r;
                end
            end
            r.status = ffra_pkg::ST_NOFIT;
            return r;
        end
        if (first > last) begin
            r.status = ffra_pkg::ST_BAD;
            return r;
        end
        if (free_cnt >= ffra_pkg::MAX_RANGES_DEF) begin
            r.status = ffra_pkg::ST_FULL;
            return r;
        end
        idx = 0;
        while (idx < free_cnt && free_lo[idx] < first) idx++;
        ladj = idx > 0 && free_hi[idx - 1] + 1 == first;
        radj = idx < free_cnt && last + 1 == free_lo[idx];
        if (ladj && radj) begin
            free_hi[idx - 1] = free_hi[idx];
            for (int unsigned k = idx; k + 1 < free_cnt; k++) begin
                free_lo[k] = free_lo[k + 1];
                free_hi[k] = free_hi[k + 1];
            end
            free_cnt--;
        end else if (ladj) begin
            free_hi[idx - 1] = last;
        end else if (radj) begin
            free_lo[idx] = first;
        end else begin
            for (int unsigned k = free_cnt; k > idx; k--) begin
                free_lo[k] = free_lo[k - 1];
                free_hi[k] = free_hi[k - 1];
            end
            free_lo[idx] = first;
            free_hi[idx] = last;
            free_cnt++;
        end
        r.status = ffra_pkg::ST_OK;
        return r;
    endfunction

    task automatic send_request(input logic op, input logic [15:0] cnt,
                                input logic [15:0] first, input logic [15:0] last,
                                output t_reply r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_operation     <= op;
        i_alloc_count   <= cnt;
        i_release_first <= first;
        i_release_last  <= last;
        do @(posedge i_clk); while (o_stall);
        r = free_list_step(op, cnt, first, last);
        pending_replies.push_back(r);
    endtask

    task automatic alloc(input logic [15:0] cnt);
        t_reply r;
        send_request(ffra_pkg::OP_ALLOC, cnt, 16'($urandom), 16'($urandom), r);
        if (r.status == ffra_pkg::ST_OK) held_spans.push_back({r.first, r.last});
    endtask

    task automatic release_span(input logic [15:0] first, input logic [15:0] last);
        t_reply r;
        send_request(ffra_pkg::OP_RELEASE, 16'($urandom), first, last, r);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_reply exp_r;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_replies.size() == 0) begin
                    $error("unexpected result word");
                    failed = 1'b1;
                end else begin
                    exp_r = pending_replies.pop_front();
                    if (o_status !== exp_r.status) begin
                        $error("status expected %0d actual %0d", exp_r.status, o_status);
                        failed = 1'b1;
                    end
                    if (o_granted_first !== exp_r.first) begin
                        $error("granted_first expected %0d actual %0d",
                               exp_r.first, o_granted_first);
                        failed = 1'b1;
                    end
                    if (o_granted_last !== exp_r.last) begin
                        $error("granted_last expected %0d actual %0d",
                               exp_r.last, o_granted_last);
                        failed = 1'b1;
                    end
                end
                stall_left = calm ? 0 : $urandom_range(0, 7);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_stall <= (stall_left != 0);
        end
    end

    task automatic test_directed();
        alloc(16'd0);
        alloc(16'hFFFF);
        alloc(16'd1);
        release_span(16'd5, 16'd4);
        release_span(16'hFFFF, 16'hFFFF);
        release_span(16'd0, 16'd0);
        release_span(16'd1, 16'hFFFE);
        alloc(16'd1);
        alloc(16'h8000);
        release_span(16'd0, 16'd0);
        release_span(16'd1, 16'h8000);
        release_span(16'd10, 16'd20);
        alloc(16'hFFFF);
        alloc(16'd11);
        alloc(16'd1);
        alloc(16'd1);
        release_span(16'd0, 16'hFFFF);
        release_span(16'hAAAA, 16'h5555);
        alloc(16'h5555);
        alloc(16'hAAAA);
        release_span(16'd0, 16'hFFFF);
        held_spans.delete();
        wait_drain();
    endtask

    task automatic test_list_full();
        t_span s;
        int    guard;
        for (int i = 0; i < 160; i++) alloc(16'd1);
        while (free_cnt < ffra_pkg::MAX_RANGES_DEF && held_spans.size() > 1) begin
            s = held_spans.pop_front();
            release_span(s.first, s.last);
            void'(held_spans.pop_front());
        end
        wait_drain();
        s = held_spans.pop_front();
        release_span(s.first, s.last);
        release_span(16'h1234, 16'h1234);
        guard = 0;
        while (free_cnt > 40 && guard < 200) begin
            alloc(16'd1);
            guard++;
        end
        wait_drain();
    endtask

    task automatic test_random(input int n);
        t_span       s;
        int          pick;
        int          hidx;
        logic [15:0] cut;
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                release_span(16'($urandom), 16'($urandom));
                if (pick < 5) alloc(16'($urandom));
            end else if (pick < 55 && held_spans.size() != 0) begin
                hidx = $urandom_range(0, held_spans.size() - 1);
                s = held_spans[hidx];
                held_spans.delete(hidx);
                if (s.last > s.first && $urandom_range(0, 1)) begin
                    cut = s.first + 16'($urandom_range(0, s.last - s.first - 1));
                    held_spans.push_back({16'(cut + 1), s.last});
                    s.last = cut;
                end
                release_span(s.first, s.last);
            end else if (pick < 95) begin
                alloc(16'($urandom_range(1, 64)));
            end else begin
                alloc(16'($urandom_range(1, 65535)));
            end
        end
        calm = 1'b0;
        wait_drain();
    endtask

    initial begin
        for (int i = 0; i < ffra_pkg::MAX_RANGES_DEF; i++) begin
            free_lo[i] = 0;
            free_hi[i] = 0;
        end
        free_lo[0] = ffra_pkg::HANDLE_LOW_DEF;
        free_hi[0] = ffra_pkg::HANDLE_HIGH_DEF;
        free_cnt = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_list_full();
        test_random(580);
        repeat (150) @(posedge i_clk);
        if (!failed && pending_replies.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
